// ===== sv/jhds_pkg.sv =====
`timescale 1ns / 1ps
package jhds_pkg;

  // Marker and signature byte values.
  localparam logic [7:0] MK_STUFF   = 8'h00;
  localparam logic [7:0] MK_FF      = 8'hFF;
  localparam logic [7:0] MK_SOI     = 8'hD8;
  localparam logic [7:0] MK_EOI     = 8'hD9;
  localparam logic [7:0] MK_SOS     = 8'hDA;
  localparam logic [7:0] MK_RST0    = 8'hD0;
  localparam logic [7:0] MK_RST7    = 8'hD7;
  localparam logic [7:0] MK_SOF_LO  = 8'hC0;
  localparam logic [7:0] MK_SOF_HI  = 8'hCF;
  localparam logic [7:0] MK_DHT     = 8'hC4;
  localparam logic [7:0] MK_JPG     = 8'hC8;
  localparam logic [7:0] MK_DAC     = 8'hCC;

  // Frame header body byte positions of the dimensions.
  localparam logic [2:0] SOF_HEIGHT_HI = 3'd1;
  localparam logic [2:0] SOF_HEIGHT_LO = 3'd2;
  localparam logic [2:0] SOF_WIDTH_HI  = 3'd3;
  localparam logic [2:0] SOF_WIDTH_LO  = 3'd4;
  localparam logic [2:0] SOF_IDX_SAT   = 3'd7;

  localparam logic [15:0] LEN_MIN     = 16'd2;
  localparam logic [15:0] LEN_SOF_MIN = 16'd7;

  localparam int unsigned PADDR_W    = 3;
  localparam logic        REG_MAX_PIXELS = 1'b0;
  localparam logic [31:0] MAX_PIXELS_RST = 32'h0200_0000;

  typedef enum logic [8:0] {
    PH_SIG0  = 9'b000000001,
    PH_SIG1  = 9'b000000010,
    PH_SIG2  = 9'b000000100,
    PH_SCAN  = 9'b000001000,
    PH_MARK  = 9'b000010000,
    PH_LENHI = 9'b000100000,
    PH_LENLO = 9'b001000000,
    PH_BODY  = 9'b010000000,
    PH_DONE  = 9'b100000000
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NO_DIMS = 3'd1,
    ST_TRUNC   = 3'd2,
    ST_ZERO    = 3'd3,
    ST_LARGE   = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] width;
    logic [15:0] height;
  } out_t;

  // What the parser hands to the verdict stage at the end of a file.
  typedef struct packed {
    logic        eoi_seen;
    logic        dims_found;
    logic [15:0] width;
    logic [15:0] height;
  } capture_t;

  function automatic logic is_sof(logic [7:0] m);
    return (m >= MK_SOF_LO) && (m <= MK_SOF_HI) &&
           (m != MK_DHT) && (m != MK_JPG) && (m != MK_DAC);
  endfunction

endpackage

// ===== sv/jhds_cfg.sv =====
`timescale 1ns / 1ps
module jhds_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [jhds_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output logic [31:0]                  max_pixels_o
);
  import jhds_pkg::*;

  logic [31:0] max_pixels_q;
  logic        sel_max;

  assign sel_max = (paddr[2] == REG_MAX_PIXELS);
  assign pready  = 1'b1;
  assign prdata  = sel_max ? max_pixels_q : 32'd0;
  assign max_pixels_o = max_pixels_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_pixels_q <= MAX_PIXELS_RST;
    end else if (psel && penable && pwrite && pready && sel_max) begin
      max_pixels_q <= pwdata;
    end
  end

endmodule

// ===== sv/jhds_parser.sv =====
`timescale 1ns / 1ps
module jhds_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 acc_i,
  input  jhds_pkg::in_t        in_data_i,
  output logic                 fin_o,
  output jhds_pkg::capture_t   cap_o
);
  import jhds_pkg::*;

  phase_e      phase_q, phase_d;
  logic [15:0] seg_q, seg_d;
  logic        frame_q, frame_d;
  logic [2:0]  idx_q, idx_d;
  logic [15:0] w_q, w_d;
  logic [15:0] h_q, h_d;
  logic        dims_q, dims_d;
  logic        prev_ff_q, eoi_q, eoi_d;
  logic [7:0]  b;
  logic [15:0] len;
  logic        is_rst;

  assign b      = in_data_i.data_byte;
  assign len    = {seg_q[7:0], b};
  assign is_rst = (b >= MK_RST0) && (b <= MK_RST7);
  assign eoi_d  = eoi_q | (prev_ff_q && (b == MK_EOI));

  always_comb begin
    phase_d = phase_q;
    seg_d   = seg_q;
    frame_d = frame_q;
    idx_d   = idx_q;
    w_d     = w_q;
    h_d     = h_q;
    dims_d  = dims_q;
    unique case (phase_q)
      PH_SIG0: phase_d = (b == MK_FF) ? PH_SIG1 : PH_DONE;
      PH_SIG1: phase_d = (b == MK_SOI) ? PH_SIG2 : PH_DONE;
      PH_SIG2: phase_d = (b == MK_FF) ? PH_MARK : PH_DONE;
      PH_SCAN: begin
        if (b == MK_FF) phase_d = PH_MARK;
      end
      PH_MARK: begin
        priority if (b == MK_FF) begin
          phase_d = PH_MARK;
        end else if (b == MK_STUFF || b == MK_EOI || is_rst) begin
          phase_d = PH_SCAN;
        end else if (b == MK_SOS) begin
          phase_d = PH_DONE;
        end else begin
          frame_d = is_sof(b);
          phase_d = PH_LENHI;
        end
      end
      PH_LENHI: begin
        seg_d   = {8'h00, b};
        phase_d = PH_LENLO;
      end
      PH_LENLO: begin
        if (len < LEN_MIN || (frame_q && len < LEN_SOF_MIN)) begin
          phase_d = PH_DONE;
        end else begin
          seg_d   = len - LEN_MIN;
          idx_d   = '0;
          phase_d = (len == LEN_MIN) ? PH_SCAN : PH_BODY;
        end
      end
      PH_BODY: begin
        if (frame_q) begin
          unique case (idx_q)
            SOF_HEIGHT_HI: h_d[15:8] = b;
            SOF_HEIGHT_LO: h_d[7:0]  = b;
            SOF_WIDTH_HI:  w_d[15:8] = b;
            SOF_WIDTH_LO:  w_d[7:0]  = b;
            default: ;
          endcase
          if (idx_q != SOF_IDX_SAT) idx_d = idx_q + 3'd1;
        end
        seg_d = seg_q - 16'd1;
        if (seg_q == 16'd1) begin
          if (frame_q) begin
            dims_d  = 1'b1;
            phase_d = PH_DONE;
          end else begin
            phase_d = PH_SCAN;
          end
        end
      end
      PH_DONE: phase_d = PH_DONE;
      default: phase_d = PH_DONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_SIG0;
      seg_q     <= '0;
      frame_q   <= 1'b0;
      idx_q     <= '0;
      w_q       <= '0;
      h_q       <= '0;
      dims_q    <= 1'b0;
      prev_ff_q <= 1'b0;
      eoi_q     <= 1'b0;
    end else if (acc_i) begin
      if (in_data_i.last) begin
        // The final byte closes the file; the next byte starts a fresh one.
        phase_q   <= PH_SIG0;
        seg_q     <= '0;
        frame_q   <= 1'b0;
        idx_q     <= '0;
        w_q       <= '0;
        h_q       <= '0;
        dims_q    <= 1'b0;
        prev_ff_q <= 1'b0;
        eoi_q     <= 1'b0;
      end else begin
        phase_q   <= phase_d;
        seg_q     <= seg_d;
        frame_q   <= frame_d;
        idx_q     <= idx_d;
        w_q       <= w_d;
        h_q       <= h_d;
        dims_q    <= dims_d;
        prev_ff_q <= (b == MK_FF);
        eoi_q     <= eoi_d;
      end
    end
  end

  assign fin_o            = acc_i && in_data_i.last;
  assign cap_o.eoi_seen   = eoi_d;
  assign cap_o.dims_found = dims_d;
  assign cap_o.width      = w_d;
  assign cap_o.height     = h_d;

  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("parser phase lost its one-hot code");

  a_restart_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_o |=> (phase_q == PH_SIG0 && !dims_q && !eoi_q && !prev_ff_q))
    else $error("parser state not cleared after the final byte");

  a_dims_only_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dims_q |-> (phase_q == PH_DONE))
    else $error("dimensions captured while the segment walk goes on");

endmodule

// ===== sv/jhds_verdict.sv =====
`timescale 1ns / 1ps
module jhds_verdict (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fin_i,
  input  jhds_pkg::capture_t cap_i,
  input  logic [31:0]        max_pixels_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output jhds_pkg::out_t     out_data_o
);
  import jhds_pkg::*;

  logic     v_valid_q;
  capture_t v_q;
  logic     o_valid_q;
  out_t     o_q, o_d;
  logic     o_adv, v_adv;
  logic [31:0] area;

  assign o_adv      = !o_valid_q || !out_stall_i;
  assign v_adv      = !v_valid_q || o_adv;
  assign in_stall_o = !v_adv;

  assign area = 32'(v_q.width) * 32'(v_q.height);

  always_comb begin
    o_d.width  = v_q.dims_found ? v_q.width  : 16'd0;
    o_d.height = v_q.dims_found ? v_q.height : 16'd0;
    priority if (!v_q.eoi_seen) begin
      o_d.status = ST_TRUNC;
    end else if (!v_q.dims_found) begin
      o_d.status = ST_NO_DIMS;
    end else if (v_q.width == 16'd0 || v_q.height == 16'd0) begin
      o_d.status = ST_ZERO;
    end else if (area > max_pixels_i) begin
      o_d.status = ST_LARGE;
    end else begin
      o_d.status = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (v_adv) v_valid_q <= fin_i;
      if (o_adv) o_valid_q <= v_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_i && v_adv) v_q <= cap_i;
    if (v_valid_q && o_adv) o_q <= o_d;
  end

  assign out_valid_o = o_valid_q;
  assign out_data_o  = o_q;

  a_ok_has_dims: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_valid_q && o_q.status == ST_OK) |-> (o_q.width != 16'd0 && o_q.height != 16'd0))
    else $error("accepted verdict without both dimensions");

  a_no_dims_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_valid_q && o_q.status == ST_NO_DIMS) |-> (o_q.width == 16'd0 && o_q.height == 16'd0))
    else $error("no-dimension verdict carries dimensions");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v_valid_q && o_valid_q && out_stall_i))
    else $error("input stalled while a verdict register is free");

endmodule

// ===== sv/jpeg_header_dimension_scanner_top.sv =====
`timescale 1ns / 1ps
// Channel   Signals                               Request
// input     in_valid_i, in_stall_o, in_data_i     one file byte with its last flag
// output    out_valid_o, out_stall_i, out_data_o  one verdict per file
// config    psel, penable, pwrite, paddr, pwdata  max_pixels at byte address 0
//
// One byte is taken each cycle unless the input is stalled; the marker walk updates its state in that cycle.
// A verdict leaves the final byte through a capture register, then the area
// multiply and compare into the output register.
// Reset clears the parser and sets max_pixels to 33554432.
// Input stalls only when a verdict waits in both the capture and output registers and the output is stalled.
module jpeg_header_dimension_scanner_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  jhds_pkg::in_t                in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output jhds_pkg::out_t               out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [jhds_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import jhds_pkg::*;

  logic        acc;
  logic        fin;
  capture_t    cap;
  logic [31:0] max_pixels;

  assign acc = in_valid_i && !in_stall_o;

  jhds_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .max_pixels_o (max_pixels)
  );

  jhds_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .in_data_i (in_data_i),
    .fin_o     (fin),
    .cap_o     (cap)
  );

  jhds_verdict u_verdict (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fin_i        (fin),
    .cap_i        (cap),
    .max_pixels_i (max_pixels),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import jhds_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [PADDR_W-1:0] MAX_PIXELS_ADDR = PADDR_W'(4 * int'(REG_MAX_PIXELS));

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  jpeg_header_dimension_scanner_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Scanner state as the block should hold it.
  phase_e sc_phase = PH_SIG0;
  logic [15:0] sc_left = '0;
  logic sc_sof = 1'b0;
  logic [2:0] sc_idx = '0;
  logic [15:0] sc_w = '0;
  logic [15:0] sc_h = '0;
  logic sc_dims = 1'b0;
  logic sc_prev_ff = 1'b0;
  logic sc_eoi = 1'b0;
  logic [31:0] sc_max_pixels = MAX_PIXELS_RST;

  in_t pending_bytes[$];
  out_t verdict_q[$];
  logic [7:0] file_buf[$];
  out_t predicted;
  out_t seen;

  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_taken = 0;
  int unsigned stim_bytes = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit hold_done = 1'b0;
  bit byte_taken = 1'b0;
  bit verdict_taken = 1'b0;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;

  function automatic bit scan_byte(input in_t item, output out_t verdict);
    logic [7:0] b;
    logic [15:0] len;
    logic [63:0] area;
    b = item.data_byte;
    verdict = '0;
    if (sc_prev_ff && b == MK_EOI) sc_eoi = 1'b1;
    sc_prev_ff = (b == MK_FF);
    case (sc_phase)
      PH_SIG0: sc_phase = (b == MK_FF) ? PH_SIG1 : PH_DONE;
      PH_SIG1: sc_phase = (b == MK_SOI) ? PH_SIG2 : PH_DONE;
      PH_SIG2: sc_phase = (b == MK_FF) ? PH_MARK : PH_DONE;
      PH_SCAN: begin
        if (b == MK_FF) sc_phase = PH_MARK;
      end
      PH_MARK: begin
        // Extra FF bytes here are fill and keep the marker pending.
        if (b != MK_FF) begin
          if (b == MK_STUFF || b == MK_EOI || (b >= MK_RST0 && b <= MK_RST7)) begin
            sc_phase = PH_SCAN;
          end else if (b == MK_SOS) begin
            sc_phase = PH_DONE;
          end else begin
            sc_sof = (b >= MK_SOF_LO) && (b <= MK_SOF_HI) &&
                     (b != MK_DHT) && (b != MK_JPG) && (b != MK_DAC);
            sc_phase = PH_LENHI;
          end
        end
      end
      PH_LENHI: begin
        sc_left = {8'h00, b};
        sc_phase = PH_LENLO;
      end
      PH_LENLO: begin
        len = {sc_left[7:0], b};
        if (len < LEN_MIN || (sc_sof && len < LEN_SOF_MIN)) begin
          sc_phase = PH_DONE;
        end else begin
          sc_left = len - LEN_MIN;
          sc_idx = '0;
          sc_phase = (sc_left == '0) ? PH_SCAN : PH_BODY;
        end
      end
      PH_BODY: begin
        if (sc_sof) begin
          case (sc_idx)
            SOF_HEIGHT_HI: sc_h[15:8] = b;
            SOF_HEIGHT_LO: sc_h[7:0] = b;
            SOF_WIDTH_HI:  sc_w[15:8] = b;
            SOF_WIDTH_LO:  sc_w[7:0] = b;
            default: ;
          endcase
          if (sc_idx < SOF_IDX_SAT) sc_idx = sc_idx + 3'd1;
        end
        sc_left = sc_left - 16'd1;
        if (sc_left == '0) begin
          if (sc_sof) begin
            sc_dims = 1'b1;
            sc_phase = PH_DONE;
          end else begin
            sc_phase = PH_SCAN;
          end
        end
      end
      default: sc_phase = PH_DONE;
    endcase
    if (!item.last) return 1'b0;

    area = 64'(sc_w) * 64'(sc_h);
    if (!sc_eoi) verdict.status = ST_TRUNC;
    else if (!sc_dims) verdict.status = ST_NO_DIMS;
    else if (sc_w == '0 || sc_h == '0) verdict.status = ST_ZERO;
    else if (area > 64'(sc_max_pixels)) verdict.status = ST_LARGE;
    else verdict.status = ST_OK;
    verdict.width = sc_dims ? sc_w : 16'd0;
    verdict.height = sc_dims ? sc_h : 16'd0;

    // The next byte begins a new file.
    sc_phase = PH_SIG0;
    sc_left = '0;
    sc_sof = 1'b0;
    sc_idx = '0;
    sc_w = '0;
    sc_h = '0;
    sc_dims = 1'b0;
    sc_prev_ff = 1'b0;
    sc_eoi = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [15:0] pick_dim();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    if (r < 6) return 16'($urandom_range(1, 64));
    return 16'($urandom);
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    file_buf.insert(file_buf.size(), b);
  endfunction

  // Scan data, with every FF followed by a stuffed zero or a restart marker.
  task automatic add_entropy(input int unsigned n);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom);
      add_byte(b);
      if (b == MK_FF) begin
        if ($urandom_range(0, 4) == 0) add_byte(8'(MK_RST0 + $urandom_range(0, 7)));
        else add_byte(MK_STUFF);
      end
    end
  endtask

  task automatic add_segment();
    logic [7:0] m;
    logic [15:0] len;
    logic [15:0] h;
    logic [15:0] w;
    logic [7:0] hdr[5];
    int unsigned c;
    add_byte(MK_FF);
    if ($urandom_range(0, 3) == 0) add_byte(MK_FF);
    c = $urandom_range(0, 99);
    if (c < 40) begin
      m = 8'($urandom);
      if (m == MK_STUFF || m == MK_FF || m == MK_EOI || m == MK_SOS ||
          (m >= MK_RST0 && m <= MK_RST7)) begin
        m = 8'hE0 | {4'h0, m[3:0]};
      end
      if ($urandom_range(0, 19) == 0) len = 16'($urandom_range(0, 1));
      else len = 16'($urandom_range(2, 8));
      add_byte(m);
      add_byte(len[15:8]);
      add_byte(len[7:0]);
      for (int i = 2; i < int'(len); i++) add_byte(8'($urandom));
    end else if (c < 75) begin
      m = 8'(MK_SOF_LO + $urandom_range(0, 15));
      if (m == MK_DHT || m == MK_JPG || m == MK_DAC) m = MK_SOF_LO;
      if ($urandom_range(0, 11) == 0) len = 16'($urandom_range(2, 6));
      else len = 16'($urandom_range(7, 11));
      h = pick_dim();
      w = pick_dim();
      hdr = '{8'h08, h[15:8], h[7:0], w[15:8], w[7:0]};
      add_byte(m);
      add_byte(len[15:8]);
      add_byte(len[7:0]);
      for (int i = 0; i < int'(len) - 2; i++) begin
        add_byte((i < 5) ? hdr[i] : 8'($urandom));
      end
    end else if (c < 85) begin
      add_byte(8'(MK_RST0 + $urandom_range(0, 7)));
      add_entropy($urandom_range(0, 4));
    end else if (c < 92) begin
      add_byte(MK_STUFF);
      add_entropy($urandom_range(0, 4));
    end else if (c < 96) begin
      add_byte(MK_SOS);
      add_entropy($urandom_range(0, 6));
    end else begin
      add_byte(MK_EOI);
    end
  endtask

  task automatic queue_file();
    in_t item;
    foreach (file_buf[i]) begin
      item.data_byte = file_buf[i];
      item.last = (i == file_buf.size() - 1);
      pending_bytes.insert(pending_bytes.size(), item);
    end
    stim_bytes += file_buf.size();
    file_buf.delete();
  endtask

  task automatic gen_file();
    int unsigned kind;
    int unsigned idx;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 20)) add_byte(8'($urandom));
      if ($urandom_range(0, 2) == 0) begin
        add_byte(MK_FF);
        add_byte(MK_EOI);
      end
    end else begin
      // The third signature byte is the FF that opens the first marker.
      add_byte(MK_FF);
      add_byte(MK_SOI);
      repeat ($urandom_range(1, 4)) add_segment();
      add_entropy($urandom_range(0, 8));
      if ($urandom_range(0, 9) != 0) begin
        add_byte(MK_FF);
        add_byte(MK_EOI);
      end
      if (kind < 25) begin
        idx = $urandom_range(0, file_buf.size() - 1);
        file_buf[idx] = 8'($urandom);
      end
      if ($urandom_range(0, 9) == 0 && file_buf.size() > 1) begin
        repeat ($urandom_range(1, file_buf.size() - 1)) void'(file_buf.pop_back());
      end
    end
    queue_file();
  endtask

  task automatic apb_access(input bit is_write, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= MAX_PIXELS_ADDR;
    pwdata <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    if (is_write) sc_max_pixels = wdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_bytes.size() != 0 || in_valid_i || verdict_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // A request is taken at a rising edge with valid high and stall low.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      byte_taken = 1'b1;
      bytes_taken++;
      if (scan_byte(in_data_i, predicted)) verdict_q.insert(verdict_q.size(), predicted);
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !byte_taken)) begin
      if (byte_taken) begin
        byte_taken = 1'b0;
        if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
        gap_left = tx_burst ? 0 : $urandom_range(0, 13);
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        in_data_i <= pending_bytes.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      verdict_taken = 1'b1;
      seen = out_data_o;
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected verdict status=%0d width=%0d height=%0d",
                 $time, seen.status, seen.width, seen.height);
        errors++;
      end else begin
        predicted = verdict_q.pop_front();
        if (seen.status != predicted.status) begin
          $display("%0t: status expected %0d actual %0d", $time, predicted.status, seen.status);
          errors++;
        end
        if (seen.width != predicted.width) begin
          $display("%0t: width expected %0d actual %0d", $time, predicted.width, seen.width);
          errors++;
        end
        if (seen.height != predicted.height) begin
          $display("%0t: height expected %0d actual %0d", $time, predicted.height, seen.height);
          errors++;
        end
      end
    end
  end

  // One long hold-off on the verdict side, so that the input ends up stalled.
  always @(posedge clk_i) begin
    if (!hold_done && bytes_taken >= 300) begin
      hold_left = 400;
      hold_done = 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
    end
  end

  always @(negedge clk_i) begin
    if (verdict_taken) begin
      verdict_taken = 1'b0;
      if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
      stall_left = rx_burst ? 0 : $urandom_range(0, 13);
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall_i <= (hold_left > 0) || (stall_left > 0);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    logic [31:0] rd;
    logic [31:0] limits[6];
    int unsigned target;
    limits = '{32'hFFFF_FFFF, 32'd1, 32'd4096, 32'($urandom), MAX_PIXELS_RST, 32'd100000};
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Accepted frame, bad signature with an end marker, a lone byte, scan start.
    file_buf = '{8'hFF, 8'hD8, 8'hFF, 8'hC0, 8'h00, 8'h07, 8'h08,
                 8'h00, 8'h02, 8'h00, 8'h03, 8'hFF, 8'hD9};
    queue_file();
    file_buf = '{8'hFF, 8'hD9};
    queue_file();
    file_buf = '{8'h00};
    queue_file();
    file_buf = '{8'hFF, 8'hD8, 8'hFF, 8'hDA, 8'hFF, 8'hD9};
    queue_file();
    target = stim_bytes + 100;
    while (stim_bytes < target) gen_file();
    wait_idle();

    foreach (limits[i]) begin
      apb_access(1'b1, limits[i], rd);
      apb_access(1'b0, '0, rd);
      if (rd != limits[i]) begin
        $display("%0t: max_pixels readback expected %0d actual %0d", $time, limits[i], rd);
        errors++;
      end
      target = stim_bytes + 115;
      while (stim_bytes < target) gen_file();
      wait_idle();
    end

    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
